[rtl/tmte_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the text-mode terminal engine.
// No dependencies.
package tmte_pkg;

    localparam int COLS       = 80;
    localparam int ROWS       = 25;
    localparam int TAB_WIDTH  = 8;
    localparam int TAB_SHIFT  = $clog2(TAB_WIDTH);
    localparam int CELL_COUNT = COLS * ROWS;
    localparam int COPY_N     = (ROWS - 1) * COLS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 11;
    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int CLR_W  = 4;

    localparam logic [1:0] OP_PUTC  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
    localparam logic [CLR_W-1:0]  CLR_WHITE    = 4'hF;

    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    typedef enum logic [3:0] {
        K_NOP,
        K_PRINT,
        K_NEWLINE,
        K_TAB,
        K_RETURN,
        K_BACK,
        K_CLEAR,
        K_FILL,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] index;
    } t_cmd;

endpackage

[rtl/tmte_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input transactions, decodes them into commands and
// queues them for the executor. Depends on tmte_pkg.
module tmte_front import tmte_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // [7:0] char_code, [18:8] cell_index
    input  logic [1:0]        s_axis_tuser,   // [1:0] opcode
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       r_in_rdy;
    logic       push;
    logic       pop;
    t_cmd       dec;
    logic [CHAR_W-1:0] ch;

    assign ch = s_axis_tdata[CHAR_W-1:0];

    always_comb begin
        dec.ch    = ch;
        dec.index = s_axis_tdata[CHAR_W +: ADDR_W];
        dec.kind  = K_NOP;
        unique case (s_axis_tuser)
            OP_CLEAR: dec.kind = K_CLEAR;
            OP_FILL:  dec.kind = K_FILL;
            OP_READ:  dec.kind = K_READ;
            OP_PUTC: begin
                if (ch[CHAR_W-1]) begin
                    dec.kind = K_NOP;
                end else if (ch >= CH_BLANK) begin
                    dec.kind = K_PRINT;
                end else begin
                    unique case (ch)
                        CH_NEWLINE:   dec.kind = K_NEWLINE;
                        CH_TAB:       dec.kind = K_TAB;
                        CH_RETURN:    dec.kind = K_RETURN;
                        CH_BACKSPACE: dec.kind = K_BACK;
                        default:      dec.kind = K_NOP;
                    endcase
                end
            end
            default: dec.kind = K_NOP;
        endcase
    end

    assign s_axis_tready = r_in_rdy;
    assign push          = s_axis_tvalid && r_in_rdy;
    assign pop           = i_cmd_pop && (r_count != 2'd0);
    assign o_cmd_valid   = (r_count != 2'd0);
    assign o_cmd         = r_q[r_rptr];

    always_comb begin
        n_count = r_count + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr   <= 1'b0;
            r_rptr   <= 1'b0;
            r_count  <= 2'd0;
            r_in_rdy <= 1'b0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count  <= n_count;
            r_in_rdy <= (n_count != 2'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= dec;
        end
    end

endmodule

[rtl/tmte_back.sv]
`timescale 1ns / 1ps
// Back end: executes queued commands on the screen memory and the cursor,
// runs scroll and fill sweeps, and holds the result register. Depends on tmte_pkg.
module tmte_back import tmte_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_pop,
    input  logic [CLR_W-1:0]   i_fg,
    input  logic [CLR_W-1:0]   i_bg,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [31:0]        m_axis_tdata    // [6:0] cursor_col, [11:7] cursor_row,
                                               // [27:12] cell_value
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_SCROLL = 4'b0100,
        S_FILL   = 4'b1000
    } t_state;

    logic [CELL_W-1:0] mem [CELL_COUNT];

    t_state            r_state;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_cnt;
    logic [CELL_W-1:0] r_fill_val;
    logic              r_wpend;
    logic [ADDR_W-1:0] r_waddr;
    logic [CELL_W-1:0] r_rd_data;

    logic              r_out_valid;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [CELL_W-1:0] r_out_cell;

    logic              slot_free;
    logic              take;
    logic [COL_W:0]    x_n;
    logic [COL_W:0]    x_t;
    logic [ROW_W:0]    y_n;
    logic              scroll;
    logic [ADDR_W-1:0] cur_addr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
    logic              emit;
    logic [COL_W-1:0]  emit_col;
    logic [ROW_W-1:0]  emit_row;
    logic [CELL_W-1:0] emit_cell;

    assign slot_free = !r_out_valid || m_axis_tready;
    assign take      = (r_state == S_IDLE) && i_cmd_valid && slot_free;
    assign o_cmd_pop = take;

    assign cur_addr = ADDR_W'(r_row) * ADDR_W'(COLS) + ADDR_W'(r_col);

    // cursor motion for put char
    always_comb begin
        x_n = {1'b0, r_col};
        y_n = {1'b0, r_row};
        x_t = ({1'b0, r_col} >> TAB_SHIFT) + (COL_W+1)'(1);
        case (i_cmd.kind)
            K_PRINT:   x_n = {1'b0, r_col} + (COL_W+1)'(1);
            K_NEWLINE: begin
                x_n = '0;
                y_n = {1'b0, r_row} + (ROW_W+1)'(1);
            end
            K_TAB:     x_n = x_t << TAB_SHIFT;
            K_RETURN:  x_n = '0;
            K_BACK:    x_n = (r_col != '0) ? {1'b0, r_col} - (COL_W+1)'(1) : {1'b0, r_col};
            default:   x_n = {1'b0, r_col};
        endcase
        if (x_n >= (COL_W+1)'(COLS)) begin
            x_n = '0;
            y_n = y_n + (ROW_W+1)'(1);
        end
        scroll = (y_n == (ROW_W+1)'(ROWS));
    end

    // memory ports
    always_comb begin
        we    = 1'b0;
        waddr = cur_addr;
        wdata = {i_bg, i_fg, i_cmd.ch};
        if (r_wpend) begin
            we    = 1'b1;
            waddr = r_waddr;
            wdata = r_rd_data;
        end else if (r_state == S_FILL) begin
            we    = 1'b1;
            waddr = r_cnt;
            wdata = r_fill_val;
        end else if (take && (i_cmd.kind == K_PRINT)) begin
            we    = 1'b1;
        end
        raddr = (r_state == S_SCROLL) ? r_cnt + ADDR_W'(COLS) : i_cmd.index;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[raddr];
    end

    // result selection
    always_comb begin
        emit      = 1'b0;
        emit_col  = r_col;
        emit_row  = r_row;
        emit_cell = '0;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (i_cmd.kind) inside
                        K_CLEAR, K_FILL: emit = 1'b0;
                        K_READ:          emit = (i_cmd.index >= ADDR_W'(CELL_COUNT));
                        default: begin
                            emit     = !scroll;
                            emit_col = x_n[COL_W-1:0];
                            emit_row = y_n[ROW_W-1:0];
                        end
                    endcase
                end
            end
            S_READ: begin
                emit      = 1'b1;
                emit_cell = r_rd_data;
            end
            S_FILL:   emit = (r_cnt == ADDR_W'(CELL_COUNT - 1));
            S_SCROLL: emit = 1'b0;
            default:  emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_cnt       <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wpend <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        case (i_cmd.kind)
                            K_CLEAR: begin
                                r_col   <= '0;
                                r_row   <= '0;
                                r_cnt   <= '0;
                                r_state <= S_FILL;
                            end
                            K_FILL: begin
                                r_cnt   <= '0;
                                r_state <= S_FILL;
                            end
                            K_READ: begin
                                if (i_cmd.index < ADDR_W'(CELL_COUNT)) begin
                                    r_state <= S_READ;
                                end
                            end
                            default: begin
                                r_col <= x_n[COL_W-1:0];
                                if (scroll) begin
                                    r_row   <= ROW_W'(ROWS - 1);
                                    r_cnt   <= '0;
                                    r_state <= S_SCROLL;
                                end else begin
                                    r_row <= y_n[ROW_W-1:0];
                                end
                            end
                        endcase
                    end
                end
                S_READ: r_state <= S_IDLE;
                S_SCROLL: begin
                    if (r_cnt < ADDR_W'(COPY_N)) begin
                        r_wpend <= 1'b1;
                        r_cnt   <= r_cnt + ADDR_W'(1);
                    end else begin
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_cnt <= r_cnt + ADDR_W'(1);
                    if (r_cnt == ADDR_W'(CELL_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= r_cnt;
        if (take) begin
            case (i_cmd.kind)
                K_CLEAR: r_fill_val <= {i_bg, i_fg, CH_BLANK};
                K_FILL:  r_fill_val <= {i_bg, i_fg, i_cmd.ch};
                default: r_fill_val <= {i_bg, CLR_WHITE, CH_BLANK};
            endcase
        end
        if (emit) begin
            r_out_col  <= emit_col;
            r_out_row  <= emit_row;
            r_out_cell <= emit_cell;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_cell, r_out_row, r_out_col};

endmodule

[rtl/text_mode_terminal_engine.sv]
`timescale 1ns / 1ps
// Top level of the text-mode terminal engine: color registers, front end
// and back end. Depends on tmte_pkg, tmte_front and tmte_back.
//
// An 80x25 character screen with a cursor, one result per command. Commands
// enter a two-entry queue, so the input keeps accepting up to two commands
// while the executor works or the result waits. A put char that does not
// scroll is executed straight from idle, and a read of a valid cell goes
// through a read state. Clear and fill sweep the screen memory (one write
// port and one read port) at one cell per cycle, and a put char that scrolls
// copies 1920 cells then blanks 80. Screen memory is not cleared at reset:
// clear the screen before the first read. Write the color registers only
// while the engine is idle.
module text_mode_terminal_engine import tmte_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [CLR_W-1:0]  i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // [7:0] char_code, [18:8] cell_index
    input  logic [1:0]        s_axis_tuser,   // [1:0] opcode
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata    // [6:0] cursor_col, [11:7] cursor_row,
                                              // [27:12] cell_value
);

    logic [CLR_W-1:0] r_fg;
    logic [CLR_W-1:0] r_bg;
    logic             cmd_valid;
    t_cmd             cmd;
    logic             cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 4'd7;
            r_bg <= 4'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_FG) begin
                r_fg <= i_cfg_wdata;
            end else begin
                r_bg <= i_cfg_wdata;
            end
        end
    end

    tmte_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    tmte_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .i_fg          (r_fg),
        .i_bg          (r_bg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

[rtl/tmte_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the text-mode terminal engine, bound to the top level.
// Depends on tmte_pkg and text_mode_terminal_engine.
module tmte_checker import tmte_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    logic [2:0] r_pend;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {2'b0, in_acc} - {2'b0, out_acc};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] < COL_W'(COLS)) &&
                          (m_axis_tdata[11:7] < ROW_W'(ROWS)))
        else $error("cursor out of screen");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_pend != 3'd0)
        else $error("result without a pending transaction");

endmodule

bind text_mode_terminal_engine tmte_checker u_tmte_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
